FILE: hw/rtl/lfst_pkg.sv
// ----------------------------------------------------------------------------
// lfst_pkg
// Types and constants shared by the format string tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lfst_pkg;

	typedef logic [7:0] char_t;
	typedef logic [2:0] event_t;
	typedef logic [4:0] dir_code_t;

	// event codes
	localparam event_t EV_LIT     = 3'd0;
	localparam event_t EV_KEYB    = 3'd1;
	localparam event_t EV_DIR     = 3'd2;
	localparam event_t EV_END     = 3'd3;
	localparam event_t EV_ENDPCT  = 3'd4;
	localparam event_t EV_UNTERM  = 3'd5;
	localparam event_t EV_UNKNOWN = 3'd6;
	localparam event_t EV_NOKEY   = 3'd7;

	// directive codes
	localparam dir_code_t DIR_NONE     = 5'd0;
	localparam dir_code_t DIR_PERCENT  = 5'd1;
	localparam dir_code_t DIR_REM_ADDR = 5'd2;
	localparam dir_code_t DIR_LOC_ADDR = 5'd3;
	localparam dir_code_t DIR_B_LOW    = 5'd4;
	localparam dir_code_t DIR_B_UP     = 5'd5;
	localparam dir_code_t DIR_C_UP     = 5'd6;
	localparam dir_code_t DIR_D_UP     = 5'd7;
	localparam dir_code_t DIR_ENV      = 5'd8;
	localparam dir_code_t DIR_F_LOW    = 5'd9;
	localparam dir_code_t DIR_REQ_HDR  = 5'd12;
	localparam dir_code_t DIR_M_LOW    = 5'd13;
	localparam dir_code_t DIR_RSP_HDR  = 5'd14;
	localparam dir_code_t DIR_P_LOW    = 5'd15;
	localparam dir_code_t DIR_Q_LOW    = 5'd16;
	localparam dir_code_t DIR_R_LOW    = 5'd17;
	localparam dir_code_t DIR_S_LOW    = 5'd18;
	localparam dir_code_t DIR_T_LOW    = 5'd19;
	localparam dir_code_t DIR_T_UP     = 5'd20;
	localparam dir_code_t DIR_U_LOW    = 5'd21;
	localparam dir_code_t DIR_U_UP     = 5'd22;
	localparam dir_code_t DIR_V_LOW    = 5'd23;
	localparam dir_code_t DIR_V_UP     = 5'd24;
	localparam dir_code_t DIR_X_UP     = 5'd25;
	localparam dir_code_t DIR_BYTES_IN = 5'd26;
	localparam dir_code_t DIR_BYTES_OUT = 5'd27;

	localparam char_t CH_NUL     = 8'h00;
	localparam char_t CH_PERCENT = 8'h25;
	localparam char_t CH_LT      = 8'h3C;
	localparam char_t CH_GT      = 8'h3E;
	localparam char_t CH_LBRACE  = 8'h7B;
	localparam char_t CH_RBRACE  = 8'h7D;

	typedef struct packed {
		logic      hit;
		dir_code_t code;
		logic      needs_key;
	} id_info_t;

	typedef struct packed {
		event_t    event_res;
		char_t     byte_out;
		dir_code_t directive_code;
		logic      new_entry;
		logic      key_given;
	} token_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lfst_if.sv
// ----------------------------------------------------------------------------
// lfst_if
// Valid/ready channels for format string bytes and token results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfst_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

interface lfst_token_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [7:0] byte_out;
	logic [4:0] directive_code;
	logic       new_entry;
	logic       key_given;

	modport source (output valid, output event_res, output byte_out,
		output directive_code, output new_entry, output key_given, input ready);
	modport sink (input valid, input event_res, input byte_out,
		input directive_code, input new_entry, input key_given, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lfst_id_rom.sv
// ----------------------------------------------------------------------------
// lfst_id_rom
// Identifier letter table: letter to directive code and key requirement.
// ----------------------------------------------------------------------------
`default_nettype none

module lfst_id_rom (
	input  lfst_pkg::char_t  ch,
	output lfst_pkg::id_info_t info
);
	import lfst_pkg::*;

	always_comb begin
		info = '{hit: 1'b1, code: DIR_NONE, needs_key: 1'b0};
		case (ch)
			"%": info.code = DIR_PERCENT;
			"a", "h": info.code = DIR_REM_ADDR;
			"A": info.code = DIR_LOC_ADDR;
			"b": info.code = DIR_B_LOW;
			"B": info.code = DIR_B_UP;
			"C": info.code = DIR_C_UP;
			"D": info.code = DIR_D_UP;
			"e": begin
				info.code      = DIR_ENV;
				info.needs_key = 1'b1;
			end
			"f": info.code = DIR_F_LOW;
			"i": begin
				info.code      = DIR_REQ_HDR;
				info.needs_key = 1'b1;
			end
			"m": info.code = DIR_M_LOW;
			"o": begin
				info.code      = DIR_RSP_HDR;
				info.needs_key = 1'b1;
			end
			"p": info.code = DIR_P_LOW;
			"q": info.code = DIR_Q_LOW;
			"r": info.code = DIR_R_LOW;
			"s": info.code = DIR_S_LOW;
			"t": info.code = DIR_T_LOW;
			"T": info.code = DIR_T_UP;
			"u": info.code = DIR_U_LOW;
			"U": info.code = DIR_U_UP;
			"v": info.code = DIR_V_LOW;
			"V": info.code = DIR_V_UP;
			"X": info.code = DIR_X_UP;
			"I": info.code = DIR_BYTES_IN;
			"O": info.code = DIR_BYTES_OUT;
			default: info.hit = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/lfst_parser.sv
// ----------------------------------------------------------------------------
// lfst_parser
// Parse state machine: takes one byte per step and forms at most one token.
// ----------------------------------------------------------------------------
`default_nettype none

module lfst_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  lfst_pkg::char_t  ch,
	output logic             has_token,
	output lfst_pkg::token_t token
);
	import lfst_pkg::*;

	typedef enum logic [5:0] {
		PH_TEXT    = 6'b000001,
		PH_PCT     = 6'b000010,
		PH_ANGLE   = 6'b000100,
		PH_KEY     = 6'b001000,
		PH_AFTKEY  = 6'b010000,
		PH_SWALLOW = 6'b100000
	} phase_t;

	phase_t   phase_q, phase_d;
	logic     lit_run_q, lit_run_d;
	logic     key_q, key_d;
	id_info_t id;
	logic     is_nul;

	lfst_id_rom u_id_rom (
		.ch   (ch),
		.info (id)
	);

	assign is_nul = (ch == CH_NUL);

	always_comb begin
		phase_d   = phase_q;
		lit_run_d = lit_run_q;
		key_d     = key_q;
		has_token = 1'b0;
		token     = '{event_res: EV_LIT, byte_out: ch, directive_code: DIR_NONE,
			new_entry: 1'b0, key_given: 1'b0};

		case (phase_q)
			PH_TEXT: begin
				if (is_nul) begin
					lit_run_d       = 1'b0;
					has_token       = 1'b1;
					token.event_res = EV_END;
				end else if (ch == CH_PERCENT) begin
					lit_run_d = 1'b0;
					key_d     = 1'b0;
					phase_d   = PH_PCT;
				end else begin
					lit_run_d       = 1'b1;
					has_token       = 1'b1;
					token.new_entry = !lit_run_q;
				end
			end
			PH_KEY: begin
				if (is_nul) begin
					phase_d         = PH_TEXT;
					has_token       = 1'b1;
					token.event_res = EV_UNTERM;
				end else if (ch == CH_RBRACE) begin
					phase_d = PH_AFTKEY;
				end else begin
					has_token       = 1'b1;
					token.event_res = EV_KEYB;
				end
			end
			PH_PCT, PH_ANGLE, PH_AFTKEY: begin
				if (phase_q == PH_PCT && is_nul) begin
					phase_d         = PH_TEXT;
					has_token       = 1'b1;
					token.event_res = EV_ENDPCT;
				end else if (phase_q == PH_PCT && (ch == CH_LT || ch == CH_GT)) begin
					phase_d = PH_ANGLE;
				end else if (phase_q != PH_AFTKEY && ch == CH_LBRACE) begin
					key_d   = 1'b1;
					phase_d = PH_KEY;
				end else begin
					// identifier position
					has_token = 1'b1;
					if (!id.hit) begin
						token.event_res = EV_UNKNOWN;
						phase_d         = is_nul ? PH_TEXT : PH_SWALLOW;
					end else if (id.needs_key && !key_q) begin
						token.event_res = EV_NOKEY;
						phase_d         = PH_SWALLOW;
					end else begin
						token.event_res      = EV_DIR;
						token.directive_code = id.code;
						token.key_given      = key_q;
						phase_d              = PH_TEXT;
					end
				end
			end
			PH_SWALLOW: begin
				if (is_nul) begin
					phase_d = PH_TEXT;
				end
			end
			default: phase_d = PH_TEXT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TEXT;
			lit_run_q <= 1'b0;
			key_q     <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			lit_run_q <= lit_run_d;
			key_q     <= key_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/log_format_string_tokenizer.sv
// ----------------------------------------------------------------------------
// log_format_string_tokenizer
// Splits an access-log format string into literal, key and directive tokens.
// ----------------------------------------------------------------------------
// usage:
//   chars  - one format string byte per request; a zero byte ends the string
//   tokens - at most one token per byte: literal byte, key byte, directive,
//            end of string or one of four errors
// a byte is captured in an input register, decoded by the parse state
// machine and its token lands in the output register, where it is
// held until tokens takes it.
// throughput is one byte per cycle while tokens does not stall; the
// parse state update is the single loop that sets it. bytes that make
// no token still advance the parser.
// when tokens stalls with a token pending, the decoded byte waits in the
// input register and chars drops ready once that register is also full.
// reset puts the parser in the text phase with no open literal run and
// empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module log_format_string_tokenizer (
	input  logic                clk,
	input  logic                arst_n,
	lfst_char_if.sink           chars,
	lfst_token_if.source        tokens
);
	import lfst_pkg::*;

	logic   valid_s1;
	char_t  ch_s1;
	logic   step;
	logic   has_token;
	token_t token;
	logic   out_valid_q;
	token_t out_q;

	assign step        = valid_s1 && (!out_valid_q || tokens.ready);
	assign chars.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			ch_s1 <= chars.ch;
		end
	end

	lfst_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.ch        (ch_s1),
		.has_token (has_token),
		.token     (token)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= has_token;
		end else if (tokens.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && has_token) begin
			out_q <= token;
		end
	end

	assign tokens.valid          = out_valid_q;
	assign tokens.event_res      = out_q.event_res;
	assign tokens.byte_out       = out_q.byte_out;
	assign tokens.directive_code = out_q.directive_code;
	assign tokens.new_entry      = out_q.new_entry;
	assign tokens.key_given      = out_q.key_given;

endmodule

`default_nettype wire
